// ===== hdl/llt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types and constants of the lease lock table: slot geometry, opcodes,
// status codes, register map and the request and result records.
// ----------------------------------------------------------------------------
package llt_pkg;

  localparam int MAX_SLOTS   = 128;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int ID_W        = 8;
  localparam int STAMP_W     = 32;
  localparam int LEASE_W     = 16;
  localparam int ACTIVE_W    = 8;
  localparam int COUNT_W     = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register map: register i at byte address 4*i.
  localparam int APB_ADDR_W = 3;
  localparam logic REG_LEASE_TICKS  = 1'b0;
  localparam logic REG_ACTIVE_SLOTS = 1'b1;

  localparam logic [LEASE_W-1:0]  LEASE_TICKS_RST  = 16'd20;
  localparam logic [ACTIVE_W-1:0] ACTIVE_SLOTS_RST = 8'd100;

  typedef enum logic [1:0] {
    OP_RESERVE   = 2'd0,
    OP_UNRESERVE = 2'd1,
    OP_HEARTBEAT = 2'd2,
    OP_TICK      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_RENEWED   = 3'd1,
    ST_FREE      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_DENIED    = 3'd4,
    ST_INVALID   = 3'd5,
    ST_IGNORED   = 3'd6,
    ST_TICK_DONE = 3'd7
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] slot;
    logic [7:0] who;
    logic       idx_ok;
  } req_t;

  typedef struct packed {
    logic               success;
    status_e            status;
    logic [7:0]         holder_id;
    logic               holder_valid;
    logic               set_changed;
    logic [COUNT_W-1:0] expired_count;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/llt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/llt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llt_front
// Accepts request transfers, checks the slot index against the active slot
// count and queues the classified requests for the execution side.
// ----------------------------------------------------------------------------
module llt_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [llt_pkg::ACTIVE_W-1:0]  active_slots_i,
  input  wire logic                          s_valid_i,
  output logic                               s_ready_o,
  input  wire logic [15:0]                   s_data_i,   // slot_index, requester_id
  input  wire logic [1:0]                    s_user_i,   // operation
  output logic                               req_valid_o,
  output llt_pkg::req_t                      req_o,
  input  wire logic                          req_pop_i
);

  import llt_pkg::*;

  req_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  req_t              new_req;
  logic              push;

  always_comb begin
    new_req.op     = op_e'(s_user_i);
    new_req.slot   = s_data_i[7:0];
    new_req.who    = s_data_i[15:8];
    new_req.idx_ok = (s_data_i[7:0] < active_slots_i) &&
                     (32'(s_data_i[7:0]) < 32'(MAX_SLOTS));
  end

  assign s_ready_o   = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push        = s_valid_i && s_ready_o;
  assign req_valid_o = (count_q != '0);
  assign req_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (req_pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({push, req_pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_req;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/llt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llt_back
// Carries out queued requests against the slot table: one read-modify-write
// per request, and a sweep over every slot for a tick. Owns the time counter,
// the held flags, the owner and stamp memory and the result register.
// ----------------------------------------------------------------------------
module llt_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [llt_pkg::LEASE_W-1:0]  lease_ticks_i,
  input  wire logic                         req_valid_i,
  input  wire llt_pkg::req_t                req_i,
  output logic                              req_pop_o,
  output logic                              res_valid_o,
  output llt_pkg::result_t                  res_o,
  input  wire logic                         res_ready_i
);

  import llt_pkg::*;

  localparam int RAM_W = ID_W + STAMP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  state_e             state_q, state_d;
  req_t               cur_q, cur_d;
  logic [MAX_SLOTS-1:0] held_q, held_d;
  logic [STAMP_W-1:0] time_q, time_d;
  logic [SLOT_W:0]    cnt_q, cnt_d;
  logic               chk_v_q, chk_v_d;
  logic [SLOT_W-1:0]  chk_a_q, chk_a_d;
  logic [COUNT_W-1:0] exp_q, exp_d;
  logic               res_valid_q, res_valid_d;
  result_t            res_q, res_d;

  logic               we;
  logic [SLOT_W-1:0]  waddr;
  logic [RAM_W-1:0]   wdata;
  logic [SLOT_W-1:0]  raddr;
  logic [RAM_W-1:0]   rdata;
  logic [ID_W-1:0]    rd_owner;
  logic [STAMP_W-1:0] rd_stamp;
  logic [SLOT_W-1:0]  cur_a;
  logic               age_over;
  logic               out_free;

  llt_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_owner = rdata[RAM_W-1:STAMP_W];
  assign rd_stamp = rdata[STAMP_W-1:0];
  assign cur_a    = cur_q.slot[SLOT_W-1:0];
  // Age is taken modulo the stamp width, so time wrap-around is harmless.
  assign age_over = (time_q - rd_stamp) > {{(STAMP_W-LEASE_W){1'b0}}, lease_ticks_i};
  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    logic            h;
    logic            chg;
    logic            succ;
    status_e         st;
    logic [ID_W-1:0] own;

    state_d     = state_q;
    cur_d       = cur_q;
    held_d      = held_q;
    time_d      = time_q;
    cnt_d       = cnt_q;
    chk_v_d     = 1'b0;
    chk_a_d     = chk_a_q;
    exp_d       = exp_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    req_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = cur_a;
    wdata       = '0;
    raddr       = cur_a;
    h           = 1'b0;
    chg         = 1'b0;
    succ        = 1'b0;
    st          = ST_INVALID;
    own         = rd_owner;

    case (state_q)
      S_IDLE: begin
        raddr = req_i.slot[SLOT_W-1:0];
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          cur_d     = req_i;
          if (req_i.op == OP_TICK) begin
            time_d  = time_q + STAMP_W'(1);
            cnt_d   = '0;
            exp_d   = '0;
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (out_free) begin
          if (cur_q.idx_ok) begin
            h = held_q[cur_a];
            // A lapsed hold is dropped before a reserve or unreserve looks at it.
            if (cur_q.op != OP_HEARTBEAT && h && age_over) begin
              h   = 1'b0;
              chg = 1'b1;
            end
            case (cur_q.op)
              OP_RESERVE: begin
                if (!h) begin
                  h     = 1'b1;
                  own   = cur_q.who[ID_W-1:0];
                  we    = 1'b1;
                  wdata = {cur_q.who[ID_W-1:0], time_q};
                  succ  = 1'b1;
                  st    = ST_GRANTED;
                  chg   = 1'b1;
                end else if (rd_owner == cur_q.who[ID_W-1:0]) begin
                  we    = 1'b1;
                  wdata = {rd_owner, time_q};
                  succ  = 1'b1;
                  st    = ST_RENEWED;
                end else begin
                  st = ST_DENIED;
                end
              end
              OP_UNRESERVE: begin
                if (!h) begin
                  succ = 1'b1;
                  st   = ST_FREE;
                end else if (rd_owner != cur_q.who[ID_W-1:0]) begin
                  st = ST_DENIED;
                end else begin
                  h    = 1'b0;
                  succ = 1'b1;
                  st   = ST_RELEASED;
                  chg  = 1'b1;
                end
              end
              OP_HEARTBEAT: begin
                if (h && rd_owner == cur_q.who[ID_W-1:0]) begin
                  we    = 1'b1;
                  wdata = {rd_owner, time_q};
                  st    = ST_RENEWED;
                end else begin
                  st = ST_IGNORED;
                end
              end
              default: begin
                st = ST_TICK_DONE;
              end
            endcase
            held_d[cur_a] = h;
          end
          res_valid_d         = 1'b1;
          res_d.success       = succ;
          res_d.status        = st;
          res_d.holder_valid  = h;
          res_d.holder_id     = h ? 8'(own) : 8'd0;
          res_d.set_changed   = chg;
          res_d.expired_count = '0;
          state_d             = S_IDLE;
        end
      end

      S_SCAN: begin
        // Reads are issued one slot per cycle; each check works on the registered read data of its slot.
        raddr = cnt_q[SLOT_W-1:0];
        if (cnt_q != (SLOT_W+1)'(MAX_SLOTS)) begin
          chk_v_d = 1'b1;
          chk_a_d = cnt_q[SLOT_W-1:0];
          cnt_d   = cnt_q + (SLOT_W+1)'(1);
        end
        if (chk_v_q && held_q[chk_a_q] && age_over) begin
          held_d[chk_a_q] = 1'b0;
          if (exp_q != {COUNT_W{1'b1}}) begin
            exp_d = exp_q + COUNT_W'(1);
          end
        end
        if (cnt_q == (SLOT_W+1)'(MAX_SLOTS) && !chk_v_q && out_free) begin
          res_valid_d         = 1'b1;
          res_d.success       = 1'b0;
          res_d.status        = ST_TICK_DONE;
          res_d.holder_valid  = 1'b0;
          res_d.holder_id     = '0;
          res_d.set_changed   = (exp_q != '0);
          res_d.expired_count = exp_q;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      time_q      <= '0;
      cnt_q       <= '0;
      chk_v_q     <= 1'b0;
      exp_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      time_q      <= time_d;
      cnt_q       <= cnt_d;
      chk_v_q     <= chk_v_d;
      exp_q       <= exp_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    chk_a_q <= chk_a_d;
    res_q   <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== hdl/lease_lock_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lease_lock_table
// Table of lockable slots with leases: reserve, unreserve, heartbeat, tick.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis stream (operation in tuser, slot index and
// requester id in tdata); each produces exactly one result transfer on
// m_axis. Registers lease_ticks (0x0) and active_slots (0x4) are written
// over the APB port; the user must write them only while the table is idle,
// as the block itself does not enforce it. A two-entry queue sits behind the
// input, so requests are taken while the execution side is busy. Reserve,
// unreserve and heartbeat pass through the execution side one at a time (slot
// memory read, then update). A tick sweeps all 128 slots through the memory
// read port.
// Reset frees every slot, zeroes time and loads the register defaults; no
// clearing pass is needed. When the receiver stalls, the result is held in
// the output register, the execution side stops, and the input stalls once
// the queue is full.
// ----------------------------------------------------------------------------
module lease_lock_table (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [15:0]                       s_axis_tdata,  // [7:0] slot_index, [15:8] requester_id
  input  wire logic [1:0]                        s_axis_tuser,  // [1:0] operation
  // Result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [23:0]                            m_axis_tdata,  // [0] success, [3:1] status,
                                                                // [11:4] holder_id, [12] holder_valid,
                                                                // [13] set_changed,
                                                                // [21:14] expired_count, [23:22] zero
  // Configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [llt_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  import llt_pkg::*;

  logic [LEASE_W-1:0]  lease_ticks_q;
  logic [ACTIVE_W-1:0] active_slots_q;
  logic                cfg_wr;
  logic                req_valid;
  req_t                req;
  logic                req_pop;
  logic                res_valid;
  result_t             res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lease_ticks_q  <= LEASE_TICKS_RST;
      active_slots_q <= ACTIVE_SLOTS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LEASE_TICKS) begin
        lease_ticks_q <= pwdata[LEASE_W-1:0];
      end else begin
        active_slots_q <= pwdata[ACTIVE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_SLOTS) ? 32'(active_slots_q) : 32'(lease_ticks_q);

  llt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_slots_i(active_slots_q),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_user_i      (s_axis_tuser),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_pop_i     (req_pop)
  );

  llt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lease_ticks_i(lease_ticks_q),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .req_pop_o    (req_pop),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {2'b00, res.expired_count, res.set_changed, res.holder_valid,
                          res.holder_id, res.status, res.success};

`ifndef NO_ASSERTIONS
  a_invalid_no_effect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.status == ST_INVALID |-> !res.success && !res.holder_valid &&
                                              !res.set_changed)
    else $error("invalid index result reports an effect");

  a_expiry_only_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.status != ST_TICK_DONE |-> res.expired_count == '0)
    else $error("expired count set on a non-tick result");

  a_free_holder_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res.holder_valid |-> res.holder_id == '0)
    else $error("holder id reported for a free slot");

  a_success_codes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.success |-> res.status == ST_GRANTED || res.status == ST_RENEWED ||
                                 res.status == ST_FREE || res.status == ST_RELEASED)
    else $error("success reported with a failing status");
`endif

endmodule
`default_nettype wire
